/* src/upd_pkg.sv */
// shared types, constants and hex helpers for the percent decoder
package upd_pkg;

    localparam logic [7:0] PCT_CHAR = 8'h25;
    localparam int unsigned MAX_RESULTS = 3;

    // decoded work for one input character, handed from front to back
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [1:0]                  count;
        logic                        last;
    } upd_cmd_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } upd_qstat_t;

    function automatic logic is_hex(input logic [7:0] c);
        logic r;
        r = ((c >= 8'h30) && (c <= 8'h39)) ||
            ((c >= 8'h61) && (c <= 8'h66)) ||
            ((c >= 8'h41) && (c <= 8'h46));
        return r;
    endfunction

    // nibble value of a character already known to be a hex digit
    function automatic logic [3:0] hex_nib(input logic [7:0] c);
        logic [3:0] r;
        if (c <= 8'h39)
        begin
            r = c[3:0];
        end
        else
        begin
            r = c[3:0] + 4'd9;
        end
        return r;
    endfunction

endpackage

/* src/upd_front.sv */
// front: escape tracking and classification of each input character
module upd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    output upd_pkg::upd_cmd_t cmd,
    output logic             push
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PCT  = 2'd1,
        PH_HEX  = 2'd2
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    logic [1:0] n;
    logic       do_idle;
    logic [7:0] dec_val;

    assign dec_val = {upd_pkg::hex_nib(held_reg), upd_pkg::hex_nib(in_byte)};

    always_comb
    begin
        cmd        = '0;
        n          = 2'd0;
        do_idle    = 1'b0;
        phase_next = PH_IDLE;
        held_next  = held_reg;
        unique case (phase_reg)
            PH_PCT:
            begin
                if (upd_pkg::is_hex(in_byte))
                begin
                    held_next  = in_byte;
                    phase_next = PH_HEX;
                end
                else
                begin
                    cmd.bytes[n] = upd_pkg::PCT_CHAR;
                    n            = n + 2'd1;
                    do_idle      = 1'b1;
                end
            end
            PH_HEX:
            begin
                if (upd_pkg::is_hex(in_byte) && (dec_val != 8'h00))
                begin
                    cmd.bytes[n] = dec_val;
                    n            = n + 2'd1;
                end
                else
                begin
                    // broken escape or %00: literal characters, then reprocess
                    cmd.bytes[n] = upd_pkg::PCT_CHAR;
                    n            = n + 2'd1;
                    cmd.bytes[n] = held_reg;
                    n            = n + 2'd1;
                    do_idle      = 1'b1;
                end
            end
            default:
            begin
                do_idle = 1'b1;
            end
        endcase
        if (do_idle)
        begin
            if (in_byte == upd_pkg::PCT_CHAR)
            begin
                phase_next = PH_PCT;
            end
            else
            begin
                cmd.bytes[n] = in_byte;
                n            = n + 2'd1;
            end
        end
        if (in_last)
        begin
            // flush anything pending at end of string
            if (phase_next == PH_PCT)
            begin
                cmd.bytes[n] = upd_pkg::PCT_CHAR;
                n            = n + 2'd1;
            end
            else if (phase_next == PH_HEX)
            begin
                cmd.bytes[n] = upd_pkg::PCT_CHAR;
                n            = n + 2'd1;
                cmd.bytes[n] = held_next;
                n            = n + 2'd1;
            end
            phase_next = PH_IDLE;
        end
        cmd.count = n;
        cmd.last  = in_last;
    end

    assign push = accept && (n != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

endmodule

/* src/upd_queue.sv */
// queue of decoded commands between front and back
module upd_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  upd_pkg::upd_cmd_t  push_cmd,
    input  logic               pop,
    output upd_pkg::upd_cmd_t  head,
    output upd_pkg::upd_qstat_t stat
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    upd_pkg::upd_cmd_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    // full in the upper bit, empty in the lower
    assign stat       = {(count_reg == FULL_CNT), (count_reg == '0)};
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* src/upd_back.sv */
// back: serialises each queued command into result characters
module upd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  upd_pkg::upd_cmd_t   head,
    input  upd_pkg::upd_qstat_t stat,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [7:0]          out_byte,
    output logic                run_last,
    output logic                string_last,
    output logic                pop
);

    logic [1:0] idx_reg;
    logic       xfer;

    assign out_valid   = !stat.empty;
    assign out_byte    = head.bytes[idx_reg];
    assign run_last    = (idx_reg == (head.count - 2'd1));
    assign string_last = run_last && head.last;
    assign xfer        = out_valid && !out_stall;
    assign pop         = xfer && run_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else if (pop)
        begin
            idx_reg <= 2'd0;
        end
        else if (xfer)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

/* src/url_percent_decoder_unit.sv */
// with the queue empty, an input's first result is offered in the cycle after it is taken
// throughput: one input per cycle while the queue has room; the back end emits one result
// per cycle while out_stall is low, so an input with k results holds it for k transfers
// the command queue (QUEUE_DEPTH entries) absorbs bursts; input stalls only when it is full
// reset: escape tracking returns to idle and the queue empties; the held digit is not cleared
module url_percent_decoder_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       string_last
);

    upd_pkg::upd_cmd_t   cmd;
    upd_pkg::upd_cmd_t   head;
    upd_pkg::upd_qstat_t qstat;
    logic                in_xfer;
    logic                push;
    logic                pop;

    // input is held off only while the command queue has no free entry
    assign in_stall = qstat.full;
    assign in_xfer  = in_valid && !in_stall;

    // front: tracks '%' and the first hex digit, builds up to three result characters
    upd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (in_xfer),
        .in_byte (in_byte),
        .in_last (in_last),
        .cmd     (cmd),
        .push    (push)
    );

    // inputs that yield nothing (a held '%' or digit) never enter the queue
    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (cmd),
        .pop      (pop),
        .head     (head),
        .stat     (qstat)
    );

    // back: walks the head command one character per transfer
    upd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .stat        (qstat),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .string_last (string_last),
        .pop         (pop)
    );

    // a queued command always carries at least one character
    a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        !qstat.empty |-> (head.count != 2'd0))
        else $error("queued command with no characters");

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.full |-> !push)
        else $error("push into full queue");

    // end of string only on the final result of an input
    a_string_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && string_last) |-> run_last)
        else $error("string_last without run_last");

    // an input ending the string always leaves something queued behind it
    a_last_yields: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && in_last) |=> !qstat.empty)
        else $error("end of string produced no result");

endmodule

/* tb/sv/tb_url_percent_decoder_unit.sv */
// self-checking testbench for the streaming percent decoder, with directed table and random strings
module tb_url_percent_decoder_unit;

    // escape tracking of the predictor
    typedef enum logic [1:0] {
        ESC_IDLE  = 2'd0,
        ESC_PCT   = 2'd1,
        ESC_DIGIT = 2'd2
    } esc_phase_t;

    // one expected output character with its end markers
    typedef struct packed {
        logic [7:0] ch;
        logic       run_end;
        logic       str_end;
    } char_result_t;

    // one row of the directed table; typed rows carry their expected characters
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       typed;
        logic [1:0] n;
        logic [7:0] r0;
        logic [7:0] r1;
        logic [7:0] r2;
    } dir_row_t;

    localparam int DIR_ROWS     = 25;
    localparam int RAND_ITEMS   = 410;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 10;

    localparam logic [7:0] CH_0  = "0";
    localparam logic [7:0] CH_9  = "9";
    localparam logic [7:0] CH_LA = "a";
    localparam logic [7:0] CH_LF = "f";
    localparam logic [7:0] CH_UA = "A";
    localparam logic [7:0] CH_UF = "F";

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_last;

    // predictor state
    esc_phase_t   esc_phase;
    logic [7:0]   held_digit;
    logic [7:0]   decoded_chars[$];
    char_result_t awaited_chars[$];

    // random strings, built up front and then streamed
    logic [7:0]   stim_ch[$];
    logic         stim_last[$];

    int  fail_count;
    int  cycle_count;
    bit  calm;

    // directed rows: extremes after reset, upper and lower case escapes, %00,
    // non-hex after '%', non-hex second digit, '%%', high bytes, end-of-string flushes
    dir_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{8'h41, 1'b0, 1'b1, 2'd1, 8'h41, 8'h00, 8'h00},
        '{8'h01, 1'b0, 1'b1, 2'd1, 8'h01, 8'h00, 8'h00},
        '{8'hff, 1'b0, 1'b1, 2'd1, 8'hff, 8'h00, 8'h00},
        '{8'h25, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h34, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h31, 1'b0, 1'b1, 2'd1, 8'h41, 8'h00, 8'h00},
        '{8'h25, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h25, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h61, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h42, 1'b0, 1'b1, 2'd1, 8'hab, 8'h00, 8'h00},
        '{8'h25, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h30, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h30, 1'b0, 1'b1, 2'd3, 8'h25, 8'h30, 8'h30},
        '{8'h25, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h47, 1'b0, 1'b1, 2'd2, 8'h25, 8'h47, 8'h00},
        '{8'h25, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h34, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h7a, 1'b0, 1'b1, 2'd3, 8'h25, 8'h34, 8'h7a},
        '{8'h25, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'hc8, 1'b0, 1'b1, 2'd2, 8'h25, 8'hc8, 8'h00},
        '{8'h46, 1'b0, 1'b1, 2'd1, 8'h46, 8'h00, 8'h00},
        '{8'h25, 1'b1, 1'b1, 2'd1, 8'h25, 8'h00, 8'h00},
        '{8'h25, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00},
        '{8'h37, 1'b1, 1'b1, 2'd2, 8'h25, 8'h37, 8'h00},
        '{8'h78, 1'b1, 1'b1, 2'd1, 8'h78, 8'h00, 8'h00}
    };

    url_percent_decoder_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .run_last    (run_last),
        .string_last (string_last)
    );

    // ---------------------------------------------------------------- predictor

    // nibble value of a hex digit, or -1 for anything else
    function automatic int digit_value(input logic [7:0] c);
        int v;
        v = -1;
        if (c >= CH_0 && c <= CH_9)
        begin
            v = int'(c - CH_0);
        end
        else if (c >= CH_LA && c <= CH_LF)
        begin
            v = int'(c - CH_LA) + 10;
        end
        else if (c >= CH_UA && c <= CH_UF)
        begin
            v = int'(c - CH_UA) + 10;
        end
        return v;
    endfunction

    // at most three characters leave for any one input
    function automatic void emit_char(input logic [7:0] c);
        if (decoded_chars.size() < 3)
        begin
            decoded_chars.push_back(c);
        end
    endfunction

    // a character seen with nothing pending
    function automatic void take_plain(input logic [7:0] c);
        if (c == upd_pkg::PCT_CHAR)
        begin
            esc_phase = ESC_PCT;
        end
        else
        begin
            emit_char(c);
        end
    endfunction

    // advance the escape tracking by one input character, leaving its output in decoded_chars
    function automatic void decode_char(input logic [7:0] c, input logic ends_string);
        int lo;
        int hi;
        logic [7:0] value;
        decoded_chars.delete();
        case (esc_phase)
            ESC_PCT:
            begin
                if (digit_value(c) >= 0)
                begin
                    held_digit = c;
                    esc_phase  = ESC_DIGIT;
                end
                else
                begin
                    emit_char(upd_pkg::PCT_CHAR);
                    esc_phase = ESC_IDLE;
                    take_plain(c);
                end
            end
            ESC_DIGIT:
            begin
                lo = digit_value(c);
                hi = digit_value(held_digit);
                value = (lo >= 0 && hi >= 0) ? 8'(hi * 16 + lo) : 8'h00;
                esc_phase = ESC_IDLE;
                if (value != 8'h00)
                begin
                    emit_char(value);
                end
                else
                begin
                    // %00 and a broken second digit both fall back to literals
                    emit_char(upd_pkg::PCT_CHAR);
                    emit_char(held_digit);
                    take_plain(c);
                end
            end
            default:
            begin
                esc_phase = ESC_IDLE;
                take_plain(c);
            end
        endcase
        if (ends_string)
        begin
            if (esc_phase == ESC_PCT)
            begin
                emit_char(upd_pkg::PCT_CHAR);
            end
            else if (esc_phase == ESC_DIGIT)
            begin
                emit_char(upd_pkg::PCT_CHAR);
                emit_char(held_digit);
            end
            esc_phase = ESC_IDLE;
        end
    endfunction

    // queue decoded_chars as awaited output, marking the end of the run and of the string
    function automatic void await_decoded(input logic ends_string);
        char_result_t r;
        for (int i = 0; i < decoded_chars.size(); i++)
        begin
            r.ch      = decoded_chars[i];
            r.run_end = (i == decoded_chars.size() - 1);
            r.str_end = ends_string && (i == decoded_chars.size() - 1);
            awaited_chars.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    // idle length: mostly none or short, now and then long; none at all while calm
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    // a hex digit of the given value, either case for letters
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
        begin
            return CH_0 + 8'(v);
        end
        return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(1, 255));
        end
        while (digit_value(c) >= 0);
        return c;
    endfunction

    function automatic void push_char(input logic [7:0] c);
        stim_ch.push_back(c);
        stim_last.push_back(1'b0);
    endfunction

    // one piece of a random string: well-formed escapes most often, the rest noise and broken ones
    function automatic void push_token();
        int r;
        logic [3:0] hi;
        logic [3:0] lo;
        r  = $urandom_range(0, 99);
        hi = 4'($urandom_range(0, 15));
        lo = 4'($urandom_range(0, 15));
        if (r < 45)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                hi = 4'd0;
                lo = 4'd0;
            end
            push_char(upd_pkg::PCT_CHAR);
            push_char(hex_char(hi));
            push_char(hex_char(lo));
        end
        else if (r < 65)
        begin
            push_char(8'($urandom_range(1, 255)));
        end
        else if (r < 75)
        begin
            push_char(upd_pkg::PCT_CHAR);
            push_char(non_hex_char());
        end
        else if (r < 85)
        begin
            push_char(upd_pkg::PCT_CHAR);
            push_char(hex_char(hi));
            push_char(non_hex_char());
        end
        else if (r < 92)
        begin
            push_char(hex_char(hi));
        end
        else
        begin
            push_char(upd_pkg::PCT_CHAR);
        end
    endfunction

    // offer one character and hold it until the decoder takes it
    task automatic offer_char(input logic [7:0] c, input logic ends_string);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= c;
        in_last  <= ends_string;
        // values read here are those sampled by this edge
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    // ---------------------------------------------------------------- clock and reset

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // ---------------------------------------------------------------- cycle limit

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------- receive side stall

    // stalls of random length with ready stretches between them, some of them long
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = pick_gap();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
            repeat (n) @(posedge clk);
        end
    end

    // ---------------------------------------------------------------- output checking

    // every transfer on the output is matched against the oldest awaited character
    always @(posedge clk)
    begin
        char_result_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_chars.size() == 0)
            begin
                fail_count++;
                $error("unexpected transfer: out_byte %h run_last %b string_last %b",
                       out_byte, run_last, string_last);
            end
            else
            begin
                w = awaited_chars.pop_front();
                if (out_byte !== w.ch)
                begin
                    fail_count++;
                    $error("out_byte: expected %h, got %h", w.ch, out_byte);
                end
                if (run_last !== w.run_end)
                begin
                    fail_count++;
                    $error("run_last: expected %b, got %b", w.run_end, run_last);
                end
                if (string_last !== w.str_end)
                begin
                    fail_count++;
                    $error("string_last: expected %b, got %b", w.str_end, string_last);
                end
            end
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial
    begin
        int idx;
        int len;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_byte     = 8'h20;
        in_last     = 1'b0;
        fail_count  = 0;
        cycle_count = 0;
        calm        = 1'b0;
        esc_phase   = ESC_IDLE;
        held_digit  = 8'h00;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed table; typed rows replace the predicted characters with the ones written in
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            offer_char(dir_rows[i].ch, dir_rows[i].last);
            decode_char(dir_rows[i].ch, dir_rows[i].last);
            if (dir_rows[i].typed)
            begin
                decoded_chars.delete();
                if (dir_rows[i].n > 2'd0) decoded_chars.push_back(dir_rows[i].r0);
                if (dir_rows[i].n > 2'd1) decoded_chars.push_back(dir_rows[i].r1);
                if (dir_rows[i].n > 2'd2) decoded_chars.push_back(dir_rows[i].r2);
            end
            await_decoded(dir_rows[i].last);
        end

        // random strings, mostly short, a few long ones
        while (stim_ch.size() < RAND_ITEMS)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 8);
            repeat (len) push_token();
            stim_last[stim_last.size() - 1] = 1'b1;
        end

        idx = 0;
        while (idx < stim_ch.size())
        begin
            // some strings go through back to back with no sender gaps
            if (idx == 0 || stim_last[idx - 1])
            begin
                calm = ($urandom_range(0, 4) == 0);
            end
            offer_char(stim_ch[idx], stim_last[idx]);
            decode_char(stim_ch[idx], stim_last[idx]);
            await_decoded(stim_last[idx]);
            idx++;
        end
        in_valid <= 1'b0;

        // drain, then keep watching the output for anything stray
        while (awaited_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* url_percent_decoder_unit.f */
src/upd_pkg.sv
src/upd_front.sv
src/upd_queue.sv
src/upd_back.sv
src/url_percent_decoder_unit.sv
tb/sv/tb_url_percent_decoder_unit.sv
